// ----- rtl/intel_hex_record_loader_assert.svh -----
// assertion macros shared by the loader's checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef INTEL_HEX_RECORD_LOADER_ASSERT_SVH
`define INTEL_HEX_RECORD_LOADER_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define IHEX_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ihex same-cycle check failed");

// next-cycle implication, quiet while in reset
`define IHEX_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ihex next-cycle check failed");

`endif

// ----- rtl/ihex_pkg.sv -----
// shared types, character codes and record codes for the hex loader
// no dependencies
package ihex_pkg;

	// ascii characters the parser looks for
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// record types acted on
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_SEG  = 8'h02;
	localparam logic [7:0] REC_LIN  = 8'h04;

	// digits per field
	localparam logic [2:0] DIGITS_BYTE = 3'd2;
	localparam logic [2:0] DIGITS_WORD = 3'd4;

	// parser phase
	typedef enum logic [2:0] {
		PH_LINE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_ADDR  = 3'd2,
		PH_TYPE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SKIP  = 3'd5
	} ihex_phase_t;

	// one pending byte write between parser and output stage
	typedef struct packed {
		logic [31:0] base;
		logic [7:0]  index;
		logic [7:0]  data;
	} ihex_wr_t;

	// hex digit value; anything else takes the low nibble of code minus '0'
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			if (c >= CH_UA && c <= CH_UF) begin
				d = c - CH_UA + 8'd10;
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = c - CH_LA + 8'd10;
			end else begin
				d = c - CH_ZERO;
			end
			return d[3:0];
		end
	endfunction

endpackage

// ----- rtl/ihex_front.sv -----
// character parser: tracks record fields and issues byte write requests
// depends on ihex_pkg
module ihex_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       text_char,
	input  logic             file_start,
	output logic             push,
	output ihex_pkg::ihex_wr_t push_data
);
	import ihex_pkg::*;

	ihex_phase_t phase_q, cur_phase, nxt_phase;
	logic [2:0]  count_q, cur_count, nxt_count, cnt_ext;
	logic [15:0] accum_q, cur_accum, nxt_accum, acc_ext;
	logic [7:0]  total_q, cur_total, nxt_total;
	logic [7:0]  index_q, cur_index, nxt_index, index_inc;
	logic [31:0] base_q, cur_base, nxt_base;
	logic [7:0]  rtype_q, cur_rtype, nxt_rtype;
	logic [31:0] offset_q, cur_offset, nxt_offset;
	logic        is_nl, is_colon, byte_done, word_done, emit;

	// file start wipes state before the character is handled
	always_comb begin
		if (file_start) begin
			cur_phase  = PH_LINE;
			cur_count  = '0;
			cur_accum  = '0;
			cur_total  = '0;
			cur_index  = '0;
			cur_base   = '0;
			cur_rtype  = '0;
			cur_offset = '0;
		end else begin
			cur_phase  = phase_q;
			cur_count  = count_q;
			cur_accum  = accum_q;
			cur_total  = total_q;
			cur_index  = index_q;
			cur_base   = base_q;
			cur_rtype  = rtype_q;
			cur_offset = offset_q;
		end
	end

	// character classification and digit shift-in
	always_comb begin
		is_nl     = (text_char == CH_NL);
		is_colon  = (text_char == CH_COLON);
		acc_ext   = {cur_accum[11:0], hex_value(text_char)};
		cnt_ext   = cur_count + 3'd1;
		byte_done = (cnt_ext == DIGITS_BYTE);
		word_done = (cnt_ext == DIGITS_WORD);
		index_inc = cur_index + 8'd1;
		emit      = !is_nl && (cur_phase == PH_DATA) && (cur_rtype == REC_DATA) && byte_done;
	end

	// next phase
	always_comb begin
		nxt_phase = cur_phase;
		if (is_nl) begin
			nxt_phase = PH_LINE;
		end else begin
			unique case (cur_phase)
				PH_LINE: begin
					nxt_phase = is_colon ? PH_COUNT : PH_SKIP;
				end
				PH_COUNT: begin
					if (byte_done) nxt_phase = PH_ADDR;
				end
				PH_ADDR: begin
					if (word_done) nxt_phase = PH_TYPE;
				end
				PH_TYPE: begin
					if (byte_done) begin
						if (acc_ext[7:0] == REC_DATA) begin
							nxt_phase = (cur_total != 8'd0) ? PH_DATA : PH_SKIP;
						end else if (acc_ext[7:0] == REC_SEG || acc_ext[7:0] == REC_LIN) begin
							nxt_phase = PH_DATA;
						end else begin
							nxt_phase = PH_SKIP;
						end
					end
				end
				PH_DATA: begin
					if (cur_rtype == REC_DATA) begin
						if (byte_done && index_inc == cur_total) nxt_phase = PH_SKIP;
					end else if (word_done) begin
						nxt_phase = PH_SKIP;
					end
				end
				default: begin
					nxt_phase = cur_phase;
				end
			endcase
		end
	end

	// field registers and requests
	always_comb begin
		nxt_count  = cur_count;
		nxt_accum  = cur_accum;
		nxt_total  = cur_total;
		nxt_index  = cur_index;
		nxt_base   = cur_base;
		nxt_rtype  = cur_rtype;
		nxt_offset = cur_offset;
		if (is_nl) begin
			nxt_count = '0;
			nxt_accum = '0;
		end else begin
			unique case (cur_phase) inside
				PH_LINE: begin
					if (is_colon) begin
						nxt_count = '0;
						nxt_accum = '0;
					end
				end
				PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA: begin
					nxt_count = cnt_ext;
					nxt_accum = acc_ext;
					if (cur_phase == PH_COUNT && byte_done) begin
						nxt_total = acc_ext[7:0];
						nxt_count = '0;
						nxt_accum = '0;
					end
					if (cur_phase == PH_ADDR && word_done) begin
						nxt_base  = {16'd0, acc_ext} + cur_offset;
						nxt_count = '0;
						nxt_accum = '0;
					end
					if (cur_phase == PH_TYPE && byte_done) begin
						nxt_rtype = acc_ext[7:0];
						nxt_index = '0;
						nxt_count = '0;
						nxt_accum = '0;
					end
					if (cur_phase == PH_DATA) begin
						if (cur_rtype == REC_DATA) begin
							if (byte_done) begin
								nxt_index = index_inc;
								nxt_count = '0;
								nxt_accum = '0;
							end
						end else if (word_done) begin
							nxt_offset = (cur_rtype == REC_SEG) ? {12'd0, acc_ext, 4'd0}
								: {acc_ext, 16'd0};
							nxt_count = '0;
							nxt_accum = '0;
						end
					end
				end
				default: begin
					nxt_count = cur_count;
				end
			endcase
		end
	end

	// write request toward the queue
	assign push              = accept && emit;
	assign push_data.base    = cur_base;
	assign push_data.index   = cur_index;
	assign push_data.data    = acc_ext[7:0];

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE;
			count_q  <= '0;
			accum_q  <= '0;
			total_q  <= '0;
			index_q  <= '0;
			base_q   <= '0;
			rtype_q  <= '0;
			offset_q <= '0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			count_q  <= nxt_count;
			accum_q  <= nxt_accum;
			total_q  <= nxt_total;
			index_q  <= nxt_index;
			base_q   <= nxt_base;
			rtype_q  <= nxt_rtype;
			offset_q <= nxt_offset;
		end
	end

endmodule

// ----- rtl/ihex_queue.sv -----
// small fifo of pending byte writes between parser and output stage
// depends on ihex_pkg
module ihex_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ihex_pkg::ihex_wr_t push_data,
	input  logic               pop,
	output ihex_pkg::ihex_wr_t pop_data,
	output logic               full,
	output logic               empty
);
	import ihex_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ihex_wr_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	// pointer step with wrap at the depth
	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		begin
			return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
		end
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/ihex_back.sv -----
// output stage: forms the byte address and holds the result for the sink
// depends on ihex_pkg
module ihex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  ihex_pkg::ihex_wr_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        write_address,
	output logic [7:0]         write_byte
);
	import ihex_pkg::*;

	logic        valid_q;
	logic [31:0] addr_q;
	logic [7:0]  byte_q;

	// load whenever the output slot is free or being drained
	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !q_empty;
		end
	end

	// record base plus byte index, wrapping at 32 bits
	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q <= q_data.base + {24'd0, q_data.index};
			byte_q <= q_data.data;
		end
	end

	assign out_valid     = valid_q;
	assign write_address = addr_q;
	assign write_byte    = byte_q;

endmodule

// ----- rtl/intel_hex_record_loader.sv -----
// intel hex loader: one text character per cycle in, one byte write out per data byte
// path: a result is queued at the edge that accepts its last digit and is then registered in the output stage
// throughput: one character per cycle; input stalls only once QUEUE_DEPTH writes
//   wait behind a stalled output stage
// reset: arst_n clears the parser to line start, the offset to zero and the queue
// to empty
module intel_hex_record_loader #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
	input  logic        s_axis_tuser,   // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [31:0] write_address, [39:32] write_byte
);
	import ihex_pkg::*;

	ihex_wr_t push_data, pop_data;
	logic     accept, push, pop, full, empty;
	logic [31:0] write_address;
	logic [7:0]  write_byte;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// parser
	ihex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_char  (s_axis_tdata),
		.file_start (s_axis_tuser),
		.push       (push),
		.push_data  (push_data)
	);

	// pending writes
	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// address forming and output register
	ihex_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.write_address (write_address),
		.write_byte    (write_byte)
	);

	assign m_axis_tdata = {write_byte, write_address};

endmodule

// ----- rtl/ihex_checker.sv -----
// port-level checks for the hex loader, bound to the top level
// depends on intel_hex_record_loader_assert.svh
`include "intel_hex_record_loader_assert.svh"

module ihex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// a stalled result stays offered unchanged
	`IHEX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`IHEX_ASSERT_NEXT(a_out_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// input back-pressure only comes from a full queue behind a stalled output
	`IHEX_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid)

	// a fresh result traces back to a request accepted on the input
	`IHEX_ASSERT_NOW(a_out_origin, $rose(m_axis_tvalid),
		$past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (.*);

// ----- tb/intel_hex_record_loader_test.sv -----
// self-checking bench for intel_hex_record_loader: text requests in, byte writes out
// depends on ihex_pkg and the loader rtl; a directed table runs first, then random lines
`timescale 1ns / 100ps

module intel_hex_record_loader_test;
	import ihex_pkg::*;

	localparam int N_DIRECTED   = 32;
	localparam int RANDOM_ITEMS = 700;
	localparam int FLOW_SPAN    = 90;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int BIG_RECORD   = 255;

	// one text request, optionally with a hand-typed write
	typedef struct packed {
		logic [7:0]  text;
		logic        start;
		logic        typed;
		logic [31:0] t_addr;
		logic [7:0]  t_byte;
	} char_req_t;

	// one byte write as seen on the output
	typedef struct packed {
		logic [31:0] address;
		logic [7:0]  data;
	} byte_write_t;

	typedef enum int {
		FLOW_FREE,
		FLOW_TX_GAPS,
		FLOW_RX_STALL,
		FLOW_BOTH
	} flow_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] text_char
	logic        s_axis_tuser;   // [0] file_start
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [31:0] write_address, [39:32] write_byte

	char_req_t   text_reqs[$];
	byte_write_t expected_writes[$];
	logic [7:0]  line_buf[$];
	flow_mode_t  flow = FLOW_FREE;
	int          hold_seq = 0;
	int          bad_count = 0;
	int          accept_idx = 0;
	int          cycle_count = 0;

	// parser mirror, reset values
	ihex_phase_t cur_phase    = PH_LINE;
	logic [2:0]  nibbles_seen = '0;
	logic [15:0] field_val    = '0;
	logic [7:0]  rec_len      = '0;
	logic [7:0]  rec_pos      = '0;
	logic [31:0] rec_base     = '0;
	logic [7:0]  rec_kind     = '0;
	logic [31:0] load_offset  = '0;

	// directed table: type 4 offset to ffff0000, then one byte at the top of memory
	char_req_t directed_rows [N_DIRECTED] = '{
		'{"x",      1'b1, 1'b0, 32'h0, 8'h00},   // file start on a line without colon
		'{CH_NL,    1'b0, 1'b0, 32'h0, 8'h00},
		'{CH_COLON, 1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"4",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"9",      1'b0, 1'b0, 32'h0, 8'h00},   // trailing text, ignored
		'{CH_NL,    1'b0, 1'b0, 32'h0, 8'h00},
		'{CH_COLON, 1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"1",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"f",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"f",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"F",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"0",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"a",      1'b0, 1'b0, 32'h0, 8'h00},
		'{"G",      1'b0, 1'b1, 32'hFFFF_FFFF, 8'hA7},   // non-hex digit reads as 7
		'{CH_NL,    1'b0, 1'b0, 32'h0, 8'h00},
		'{8'hFF,    1'b0, 1'b0, 32'h0, 8'h00},
		'{8'h00,    1'b0, 1'b0, 32'h0, 8'h00},
		'{CH_NL,    1'b0, 1'b0, 32'h0, 8'h00}
	};

	intel_hex_record_loader u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// digit value: hex letters in either case, anything else low nibble of code minus '0'
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] folded;
		logic [7:0] v;
		begin
			folded = c | 8'h20;
			if (((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)))
				v = folded - CH_LA + 8'd10;
			else
				v = c - CH_ZERO;
			return v[3:0];
		end
	endfunction

	// advance the parser mirror by one character; hit marks a byte write
	task automatic decode_char(input logic [7:0] c, input logic start, output logic hit,
			output logic [31:0] addr, output logic [7:0] data);
		begin
			hit = 1'b0;
			addr = '0;
			data = '0;
			if (start) begin
				load_offset = '0;
				cur_phase = PH_LINE;
				nibbles_seen = '0;
				field_val = '0;
				rec_len = '0;
				rec_pos = '0;
				rec_base = '0;
				rec_kind = '0;
			end
			if (c == CH_NL) begin
				cur_phase = PH_LINE;
				nibbles_seen = '0;
				field_val = '0;
			end else if (cur_phase == PH_LINE) begin
				if (c == CH_COLON) begin
					cur_phase = PH_COUNT;
					nibbles_seen = '0;
					field_val = '0;
				end else begin
					cur_phase = PH_SKIP;
				end
			end else if (cur_phase >= PH_COUNT && cur_phase <= PH_DATA) begin
				field_val = {field_val[11:0], nibble_of(c)};
				nibbles_seen = nibbles_seen + 3'd1;
				case (cur_phase)
					PH_COUNT: begin
						if (nibbles_seen == DIGITS_BYTE) begin
							rec_len = field_val[7:0];
							cur_phase = PH_ADDR;
							nibbles_seen = '0;
							field_val = '0;
						end
					end
					PH_ADDR: begin
						if (nibbles_seen == DIGITS_WORD) begin
							rec_base = {16'h0, field_val} + load_offset;
							cur_phase = PH_TYPE;
							nibbles_seen = '0;
							field_val = '0;
						end
					end
					PH_TYPE: begin
						if (nibbles_seen == DIGITS_BYTE) begin
							rec_kind = field_val[7:0];
							rec_pos = '0;
							nibbles_seen = '0;
							field_val = '0;
							if (rec_kind == REC_DATA)
								cur_phase = (rec_len != 8'd0) ? PH_DATA : PH_SKIP;
							else if (rec_kind == REC_SEG || rec_kind == REC_LIN)
								cur_phase = PH_DATA;
							else
								cur_phase = PH_SKIP;
						end
					end
					default: begin
						if (rec_kind == REC_DATA) begin
							if (nibbles_seen == DIGITS_BYTE) begin
								hit = 1'b1;
								addr = rec_base + {24'h0, rec_pos};
								data = field_val[7:0];
								rec_pos = rec_pos + 8'd1;
								nibbles_seen = '0;
								field_val = '0;
								if (rec_pos == rec_len)
									cur_phase = PH_SKIP;
							end
						end else if (nibbles_seen == DIGITS_WORD) begin
							if (rec_kind == REC_SEG)
								load_offset = {12'h0, field_val, 4'h0};
							else
								load_offset = {field_val, 16'h0};
							nibbles_seen = '0;
							field_val = '0;
							cur_phase = PH_SKIP;
						end
					end
				endcase
			end
		end
	endtask

	// hex digits msb first, mixed case, now and then a junk character
	task automatic put_digits(input logic [15:0] value, input int ndig);
		logic [3:0] nib;
		begin
			for (int i = ndig - 1; i >= 0; i--) begin
				nib = value[i*4 +: 4];
				if ($urandom_range(0, 99) < 3)
					line_buf.push_back(8'($urandom_range(11, 255)));
				else if (nib < 4'd10)
					line_buf.push_back(CH_ZERO + 8'(nib));
				else if ($urandom_range(0, 1) == 0)
					line_buf.push_back(CH_UA + 8'(nib) - 8'd10);
				else
					line_buf.push_back(CH_LA + 8'(nib) - 8'd10);
			end
		end
	endtask

	// one text line: mostly records, some noise, bad starts and cut-off lines
	task automatic build_line(input bit full_block);
		int pick;
		int len;
		int cut;
		logic [7:0]  rtype;
		logic [15:0] where;
		begin
			line_buf.delete();
			pick = full_block ? 99 : $urandom_range(0, 99);
			if (pick < 5) begin
				// raw noise, may hold anything
				repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 10) begin
				// first character is not a colon
				line_buf.push_back(8'($urandom_range(11, 57)));
				put_digits(16'($urandom), 4);
			end else begin
				pick = $urandom_range(0, 99);
				if (full_block || pick < 70)
					rtype = REC_DATA;
				else if (pick < 80)
					rtype = REC_SEG;
				else if (pick < 90)
					rtype = REC_LIN;
				else
					rtype = 8'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (full_block)
					len = BIG_RECORD;
				else if (rtype != REC_DATA)
					len = $urandom_range(0, 4);
				else if (pick < 8)
					len = 0;
				else if (pick < 13)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(1, 8);
				pick = $urandom_range(0, 99);
				where = (pick < 10) ? 16'hFFFF : (pick < 15) ? 16'h0000 : 16'($urandom);
				line_buf.push_back(CH_COLON);
				put_digits(16'(len), 2);
				put_digits(where, 4);
				put_digits({8'h0, rtype}, 2);
				if (rtype == REC_DATA)
					repeat (len) put_digits(16'($urandom_range(0, 255)), 2);
				else
					put_digits(($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom), 4);
				put_digits(16'($urandom_range(0, 255)), 2);
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 4))
						line_buf.push_back(8'($urandom_range(11, 255)));
				// record cut short by an early newline
				if (!full_block && $urandom_range(0, 99) < 6) begin
					cut = $urandom_range(1, line_buf.size() - 1);
					while (line_buf.size() > cut) void'(line_buf.pop_back());
				end
			end
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back(8'h0D);
			line_buf.push_back(CH_NL);
		end
	endtask

	function automatic bit tx_gap(input flow_mode_t f);
		case (f)
			FLOW_TX_GAPS: return $urandom_range(0, 99) < 55;
			FLOW_BOTH:    return $urandom_range(0, 99) < 22;
			default:      return 1'b0;
		endcase
	endfunction

	function automatic bit rx_stall(input flow_mode_t f);
		case (f)
			FLOW_RX_STALL: return $urandom_range(0, 99) < 55;
			FLOW_BOTH:     return $urandom_range(0, 99) < 22;
			default:       return 1'b0;
		endcase
	endfunction

	// text source, then drain and verdict
	initial begin : text_source
		int  idx;
		bit  big_done;
		logic start;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		big_done = 1'b0;
		foreach (directed_rows[i]) text_reqs.push_back(directed_rows[i]);
		while (text_reqs.size() < N_DIRECTED + RANDOM_ITEMS) begin
			build_line(!big_done && text_reqs.size() > 150);
			if (text_reqs.size() > 150)
				big_done = 1'b1;
			foreach (line_buf[i]) begin
				start = (i == 0 && $urandom_range(0, 99) < 4) || $urandom_range(0, 199) == 0;
				text_reqs.push_back('{line_buf[i], start, 1'b0, 32'h0, 8'h00});
			end
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (idx = 0; idx < text_reqs.size(); idx++) begin
			flow = flow_mode_t'((idx / FLOW_SPAN) % 4);
			// long output hold-offs while requests keep coming
			if (idx == 40 || idx == 400)
				hold_seq++;
			while (tx_gap(flow)) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= text_reqs[idx].text;
			s_axis_tuser <= text_reqs[idx].start;
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// write sink with random stalls and counted hold-offs
	initial begin : write_sink
		int hold_left;
		int hold_seen;
		m_axis_tready = 1'b0;
		hold_left = 0;
		hold_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !rx_stall(flow);
			end
		end
	end

	// predict on accepted text, compare accepted writes in order
	always @(posedge clk) begin : write_check
		logic        hit;
		logic [31:0] addr;
		logic [7:0]  data;
		byte_write_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_char(s_axis_tdata, s_axis_tuser, hit, addr, data);
				if (text_reqs[accept_idx].typed)
					expected_writes.push_back('{text_reqs[accept_idx].t_addr,
						text_reqs[accept_idx].t_byte});
				else if (hit)
					expected_writes.push_back('{addr, data});
				accept_idx++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_writes.size() == 0) begin
					$error("write with none pending: write_address %h write_byte %h",
						m_axis_tdata[31:0], m_axis_tdata[39:32]);
					bad_count++;
				end else begin
					want = expected_writes.pop_front();
					if (m_axis_tdata[31:0] !== want.address) begin
						$error("write_address expected %h actual %h",
							want.address, m_axis_tdata[31:0]);
						bad_count++;
					end
					if (m_axis_tdata[39:32] !== want.data) begin
						$error("write_byte expected %h actual %h",
							want.data, m_axis_tdata[39:32]);
						bad_count++;
					end
				end
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
